/* src/assert_macros.svh */
// Assertion macros used by the checker file lmrs_checker.sv.
// Depends on nothing; take it by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/lmrs_pkg.sv */
// Shared types and constants for the LED matrix row shifter.
// Depends on nothing; imported by the top level, frame store and pin sequencer.
`timescale 1ns / 1ps

package lmrs_pkg;

   localparam int DEFAULT_ROW_WIDTH = 32;
   localparam int DEFAULT_ROW_COUNT = 16;

   localparam int COL_X_WIDTH       = 5;
   localparam int ROW_Y_WIDTH       = 4;
   localparam int TICK_PERIOD_WIDTH = 16;

   localparam logic [TICK_PERIOD_WIDTH-1:0] TICK_PERIOD_RESET = 16'd10;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   typedef struct packed {
      logic clk;
      logic latch;
      logic oe;
      logic data;
   } pins_type;

endpackage

/* src/led_matrix_row_shifter_top.sv */
// LED matrix row shifter: each accepted beat passes an input register, then a result register;
// throughput one beat per cycle while rsp_stall does not hold a result beat.
// While a result beat stalls, the input register takes one more beat, then stalls input.
// Synchronous active-high reset clears the frame store, sequencer and valid flags, but not
// the result register's pins, and sets tick_period to 10. Depends on lmrs_pkg,
// lmrs_frame_store and lmrs_pin_sequencer.
`timescale 1ns / 1ps

module led_matrix_row_shifter_top #(
   parameter int ROW_WIDTH = lmrs_pkg::DEFAULT_ROW_WIDTH,
   parameter int ROW_COUNT = lmrs_pkg::DEFAULT_ROW_COUNT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic [lmrs_pkg::COL_X_WIDTH-1:0]       req_col_x,
   input  logic [lmrs_pkg::ROW_Y_WIDTH-1:0]       req_row_y,
   input  logic                                  req_pixel_on,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_clk_pin,
   output logic                                  rsp_latch_pin,
   output logic                                  rsp_oe_pin,
   output logic                                  rsp_data_pin,
   input  logic                                  csr_write_enable,
   input  logic [lmrs_pkg::TICK_PERIOD_WIDTH-1:0] csr_write_data
);
   import lmrs_pkg::*;

   logic                         in_valid_ff, in_valid_in;
   logic                         in_func_ff;
   logic [COL_X_WIDTH-1:0]       in_col_ff;
   logic [ROW_Y_WIDTH-1:0]       in_row_ff;
   logic                         in_on_ff;
   logic                         out_valid_ff, out_valid_in;
   pins_type                     out_pins_ff;
   pins_type                     pins_next;
   logic [TICK_PERIOD_WIDTH-1:0] tick_period_ff;
   logic [ROW_WIDTH-1:0]         row0;
   logic                         advance;
   logic                         accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff && rsp_stall;
      if (advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         tick_period_ff <= TICK_PERIOD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            tick_period_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_func_ff <= req_func;
         in_col_ff  <= req_col_x;
         in_row_ff  <= req_row_y;
         in_on_ff   <= req_pixel_on;
      end
      if (advance) begin
         out_pins_ff <= pins_next;
      end
   end

   lmrs_frame_store #(
      .ROW_WIDTH (ROW_WIDTH),
      .ROW_COUNT (ROW_COUNT)
   ) u_frame_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (advance && (in_func_ff == FUNC_PIXEL)),
      .col_x    (in_col_ff),
      .row_y    (in_row_ff),
      .pixel_on (in_on_ff),
      .row0     (row0)
   );

   lmrs_pin_sequencer #(
      .ROW_WIDTH (ROW_WIDTH)
   ) u_pin_sequencer (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (advance && (in_func_ff == FUNC_TICK)),
      .tick_period (tick_period_ff),
      .row0        (row0),
      .pins_next   (pins_next)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_clk_pin   = out_pins_ff.clk;
   assign rsp_latch_pin = out_pins_ff.latch;
   assign rsp_oe_pin    = out_pins_ff.oe;
   assign rsp_data_pin  = out_pins_ff.data;

endmodule

/* src/lmrs_frame_store.sv */
// One-bit-per-pixel frame store; column 0 sits in the most significant bit.
// Depends on lmrs_pkg. Row 0 is presented to the pin sequencer.
`timescale 1ns / 1ps

module lmrs_frame_store #(
   parameter int ROW_WIDTH = lmrs_pkg::DEFAULT_ROW_WIDTH,
   parameter int ROW_COUNT = lmrs_pkg::DEFAULT_ROW_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [lmrs_pkg::COL_X_WIDTH-1:0] col_x,
   input  logic [lmrs_pkg::ROW_Y_WIDTH-1:0] row_y,
   input  logic                            pixel_on,
   output logic [ROW_WIDTH-1:0]            row0
);
   import lmrs_pkg::*;

   localparam int COL_IDX_W = $clog2(ROW_WIDTH);
   localparam int ROW_IDX_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
   localparam int COL_NEED_W = $clog2(ROW_WIDTH + 1);
   localparam int ROW_NEED_W = $clog2(ROW_COUNT + 1);
   localparam int COL_CMP_W = (COL_NEED_W > COL_X_WIDTH) ? COL_NEED_W : COL_X_WIDTH;
   localparam int ROW_CMP_W = (ROW_NEED_W > ROW_Y_WIDTH) ? ROW_NEED_W : ROW_Y_WIDTH;

   logic [ROW_WIDTH-1:0] frame_ff [ROW_COUNT];
   logic [ROW_WIDTH-1:0] frame_in [ROW_COUNT];

   logic [COL_CMP_W-1:0] col_wide;
   logic [ROW_CMP_W-1:0] row_wide;
   logic                 hit;
   logic [COL_IDX_W-1:0] bit_pos;
   logic [ROW_IDX_W-1:0] row_idx;

   assign col_wide = COL_CMP_W'(col_x);
   assign row_wide = ROW_CMP_W'(row_y);
   assign hit      = wr_en && (col_wide < COL_CMP_W'(ROW_WIDTH))
                     && (row_wide < ROW_CMP_W'(ROW_COUNT));
   assign bit_pos  = COL_IDX_W'(ROW_WIDTH - 1) - col_wide[COL_IDX_W-1:0];
   assign row_idx  = row_wide[ROW_IDX_W-1:0];

   always_comb begin
      frame_in = frame_ff;
      if (hit) begin
         frame_in[row_idx][bit_pos] = pixel_on;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            frame_ff[r] <= '0;
         end
      end else begin
         frame_ff <= frame_in;
      end
   end

   assign row0 = frame_ff[0];

endmodule

/* src/lmrs_pin_sequencer.sv */
// Tick divider and pin sequencer: shift, latch and output-enable phases.
// Depends on lmrs_pkg; reads row 0 from lmrs_frame_store.
`timescale 1ns / 1ps

module lmrs_pin_sequencer #(
   parameter int ROW_WIDTH = lmrs_pkg::DEFAULT_ROW_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  tick_en,
   input  logic [lmrs_pkg::TICK_PERIOD_WIDTH-1:0] tick_period,
   input  logic [ROW_WIDTH-1:0]                  row0,
   output lmrs_pkg::pins_type                    pins_next
);
   import lmrs_pkg::*;

   localparam int COL_W     = $clog2(ROW_WIDTH + 1);
   localparam int COL_IDX_W = $clog2(ROW_WIDTH);

   logic [TICK_PERIOD_WIDTH-1:0] count_ff, count_in, count_inc;
   logic                         phase_ff, phase_in;
   logic                         shown_ff, shown_in;
   logic                         latch_due_ff, latch_due_in;
   logic                         latch_rel_ff, latch_rel_in;
   logic                         enable_due_ff, enable_due_in;
   logic                         enable_rel_ff, enable_rel_in;
   logic [COL_W-1:0]             column_ff, column_in;
   pins_type                     pins_ff, pins_in;
   logic [COL_IDX_W-1:0]         bit_pos;

   assign count_inc = count_ff + 1'b1;
   assign bit_pos   = COL_IDX_W'(ROW_WIDTH - 1) - column_ff[COL_IDX_W-1:0];

   always_comb begin
      count_in      = count_ff;
      phase_in      = phase_ff;
      shown_in      = shown_ff;
      latch_due_in  = latch_due_ff;
      latch_rel_in  = latch_rel_ff;
      enable_due_in = enable_due_ff;
      enable_rel_in = enable_rel_ff;
      column_in     = column_ff;
      pins_in       = pins_ff;
      if (tick_en) begin
         if (count_inc >= tick_period) begin
            phase_in = !phase_ff;
            count_in = '0;
         end else begin
            count_in = count_inc;
         end
         if (phase_in) begin
            if (latch_due_ff) begin
               pins_in.latch = 1'b1;
               latch_rel_in  = 1'b1;
            end else if (enable_due_ff) begin
               pins_in.oe    = 1'b1;
               enable_rel_in = 1'b1;
            end else begin
               pins_in.clk = 1'b1;
               shown_in    = 1'b0;
            end
         end else begin
            pins_in.clk = 1'b0;
            if (latch_rel_ff) begin
               latch_due_in  = 1'b0;
               pins_in.latch = 1'b0;
               enable_due_in = 1'b1;
               latch_rel_in  = 1'b0;
            end
            if (enable_rel_ff) begin
               enable_due_in = 1'b0;
               pins_in.oe    = 1'b0;
               enable_rel_in = 1'b0;
               shown_in      = 1'b0;
            end
            if (!shown_in) begin
               if (column_ff < COL_W'(ROW_WIDTH)) begin
                  pins_in.data = row0[bit_pos];
               end
               column_in = column_ff + 1'b1;
               shown_in  = 1'b1;
            end
         end
         // end of row: park data low and arm the latch
         if (column_in >= COL_W'(ROW_WIDTH)) begin
            column_in    = '0;
            pins_in.data = 1'b0;
            latch_due_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         phase_ff      <= 1'b0;
         shown_ff      <= 1'b0;
         latch_due_ff  <= 1'b0;
         latch_rel_ff  <= 1'b0;
         enable_due_ff <= 1'b0;
         enable_rel_ff <= 1'b0;
         column_ff     <= '0;
         pins_ff       <= '0;
      end else begin
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         shown_ff      <= shown_in;
         latch_due_ff  <= latch_due_in;
         latch_rel_ff  <= latch_rel_in;
         enable_due_ff <= enable_due_in;
         enable_rel_ff <= enable_rel_in;
         column_ff     <= column_in;
         pins_ff       <= pins_in;
      end
   end

   assign pins_next = pins_in;

endmodule

/* src/lmrs_checker.sv */
// Port-level checker for the LED matrix row shifter, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmrs_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_clk_pin,
   input logic rsp_latch_pin,
   input logic rsp_oe_pin,
   input logic rsp_data_pin
);

   logic [3:0] rsp_pins;

   assign rsp_pins = {rsp_clk_pin, rsp_latch_pin, rsp_oe_pin, rsp_data_pin};

   `ASSERT_NEXT_CYCLE(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pins))
   `ASSERT_SAME_CYCLE(a_one_strobe, clock, reset, rsp_valid, $countones(rsp_pins[3:1]) <= 1)
   `ASSERT_SAME_CYCLE(a_latch_data_low, clock, reset, rsp_valid && rsp_latch_pin, !rsp_data_pin)
   `ASSERT_SAME_CYCLE(a_oe_data_low, clock, reset, rsp_valid && rsp_oe_pin, !rsp_data_pin)

endmodule

bind led_matrix_row_shifter_top lmrs_checker u_lmrs_checker (.*);
